// ===== sv/wcrm_pkg.sv =====
// wcrm_pkg: shared widths, codes, state and control types of the windowed count rate meter
// used by every file of the block but wcrm_ram; depends on nothing

package wcrm_pkg;

   // window geometry
   localparam int WINDOW_DEPTH = 256;
   localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

   // field widths
   localparam int SAMPLE_W   = 24;
   localparam int ACTION_W   = 2;
   localparam int RES_W      = 32;
   localparam int RATE_W     = 32;
   localparam int PERM_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // running sum never exceeds depth times the largest sample
   localparam int TOTAL_W = SAMPLE_W + IDX_W;

   // divider geometry
   localparam int RATE_SHIFT     = 24;
   localparam int PERM_SCALE_W   = 10;
   localparam int PERM_PROD_W    = TOTAL_W + PERM_SCALE_W;
   localparam int NUM_W          = TOTAL_W + RATE_SHIFT;
   localparam int DEN_W          = FILL_W + RES_W;
   localparam int STEP_W         = $clog2(NUM_W + 1);
   localparam int PERM_ALIGN     = NUM_W - PERM_PROD_W;
   localparam int MEAN_ALIGN     = NUM_W - TOTAL_W;

   localparam logic [PERM_SCALE_W-1:0] PERM_SCALE = 10'd1000;

   // input actions
   localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADC    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REPORT = 2'd2;

   // window modes
   localparam logic MODE_SAMPLES = 1'b0;
   localparam logic MODE_SUM     = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTINUOUS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_RES    = 2'd3;

   // register reset values
   localparam logic [SAMPLE_W-1:0] TARGET_INIT    = 24'd256;
   localparam logic                CONT_INIT      = 1'b1;
   localparam logic [RES_W-1:0]    TIME_RES_INIT  = 32'd65536;

   typedef struct packed {
      logic push;
      logic drop;
   } ring_cmd_type;

   typedef struct packed {
      logic [FILL_W-1:0]   fill;
      logic [TOTAL_W-1:0]  total;
      logic [SAMPLE_W-1:0] oldest;
   } ring_stat_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_CNT_CHK,
      ST_CNT_WAIT,
      ST_ADC_CHK,
      ST_ADC_WAIT,
      ST_RATE_LD,
      ST_RATE_RUN,
      ST_PERM_LD,
      ST_PERM_RUN,
      ST_MEAN_LD,
      ST_MEAN_RUN,
      ST_DONE
   } seq_state_type;

endpackage

// ===== sv/wcrm_req_if.sv =====
// wcrm_req_if: valid/ready channel that carries one sample or report request
// depends on wcrm_pkg for field widths

interface wcrm_req_if;
   logic                          valid;
   logic                          ready;
   logic [wcrm_pkg::ACTION_W-1:0] action;
   logic                          frame_ok;
   logic [wcrm_pkg::SAMPLE_W-1:0] value;

   modport source (output valid, action, frame_ok, value, input ready);
   modport sink   (input valid, action, frame_ok, value, output ready);
endinterface

// ===== sv/wcrm_rsp_if.sv =====
// wcrm_rsp_if: valid/ready channel that carries one measurement report
// depends on wcrm_pkg for field widths

interface wcrm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wcrm_pkg::RATE_W-1:0]   mean_rate;
   logic [wcrm_pkg::SAMPLE_W-1:0] adc_mean;
   logic [wcrm_pkg::PERM_W-1:0]   completed_permille;
   logic                          stop_request;

   modport source (output valid, mean_rate, adc_mean, completed_permille, stop_request,
                   input ready);
   modport sink   (input valid, mean_rate, adc_mean, completed_permille, stop_request,
                   output ready);
endinterface

// ===== sv/wcrm_ram.sv =====
// wcrm_ram: generic single-write, single-read RAM with registered read data
// stand-alone; no package needed

module wcrm_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wcrm_ring.sv =====
// wcrm_ring: one sliding window - ring pointers, fill count and running sum around a RAM
// depends on wcrm_pkg and wcrm_ram; the oldest entry reads in the cycle after head settles

module wcrm_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  wcrm_pkg::ring_cmd_type        cmd,
   input  logic [wcrm_pkg::SAMPLE_W-1:0] push_value,
   output wcrm_pkg::ring_stat_type       stat
);

   logic [wcrm_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [wcrm_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [wcrm_pkg::TOTAL_W-1:0]  total_ff, total_in;

   logic [wcrm_pkg::IDX_W-1:0]    head_inc;
   logic [wcrm_pkg::FILL_W:0]     tail_sum;
   logic [wcrm_pkg::FILL_W:0]     tail_wrap;
   logic [wcrm_pkg::IDX_W-1:0]    tail;
   logic                          full;
   logic                          wr_en;
   logic [wcrm_pkg::SAMPLE_W-1:0] oldest;

   assign full     = (fill_ff == wcrm_pkg::FILL_W'(wcrm_pkg::WINDOW_DEPTH));
   assign head_inc = (head_ff == wcrm_pkg::IDX_W'(wcrm_pkg::WINDOW_DEPTH - 1)) ?
                     '0 : head_ff + 1'b1;

   // write slot is head + fill modulo the depth; equals head when full
   assign tail_sum  = (wcrm_pkg::FILL_W + 1)'(head_ff) + (wcrm_pkg::FILL_W + 1)'(fill_ff);
   assign tail_wrap = (tail_sum >= (wcrm_pkg::FILL_W + 1)'(wcrm_pkg::WINDOW_DEPTH)) ?
                      tail_sum - (wcrm_pkg::FILL_W + 1)'(wcrm_pkg::WINDOW_DEPTH) : tail_sum;
   assign tail      = tail_wrap[wcrm_pkg::IDX_W-1:0];

   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      wr_en    = 1'b0;
      if (cmd.push) begin
         wr_en = 1'b1;
         if (full) begin
            // overwrite the oldest entry
            total_in = total_ff - wcrm_pkg::TOTAL_W'(oldest)
                     + wcrm_pkg::TOTAL_W'(push_value);
            head_in  = head_inc;
         end else begin
            total_in = total_ff + wcrm_pkg::TOTAL_W'(push_value);
            fill_in  = fill_ff + 1'b1;
         end
      end else if (cmd.drop && (fill_ff != '0)) begin
         total_in = total_ff - wcrm_pkg::TOTAL_W'(oldest);
         head_in  = head_inc;
         fill_in  = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fill_ff  <= '0;
         total_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
      end
   end

   wcrm_ram #(
      .WIDTH (wcrm_pkg::SAMPLE_W),
      .DEPTH (wcrm_pkg::WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (push_value),
      .rd_addr (head_ff),
      .rd_data (oldest)
   );

   assign stat.fill   = fill_ff;
   assign stat.total  = total_ff;
   assign stat.oldest = oldest;

endmodule

// ===== sv/wcrm_div.sv =====
// wcrm_div: shared restoring divider, one quotient bit per cycle
// depends on wcrm_pkg; numerator comes left-aligned, steps gives its significant width

module wcrm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  wcrm_pkg::div_cmd_type      cmd,
   input  logic [wcrm_pkg::NUM_W-1:0] num,
   input  logic [wcrm_pkg::DEN_W-1:0] den,
   output wcrm_pkg::div_stat_type     stat,
   output logic [wcrm_pkg::NUM_W-1:0] quot
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [wcrm_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [wcrm_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [wcrm_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [wcrm_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [wcrm_pkg::NUM_W-1:0]  quot_ff, quot_in;

   logic [wcrm_pkg::DEN_W:0]    trial;
   logic [wcrm_pkg::DEN_W:0]    diff;
   logic                        fits;

   assign trial = {rem_ff, num_ff[wcrm_pkg::NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[wcrm_pkg::DEN_W-1:0] : trial[wcrm_pkg::DEN_W-1:0];
         quot_in = {quot_ff[wcrm_pkg::NUM_W-2:0], fits};
         num_in  = num_ff << 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == wcrm_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule

// ===== sv/windowed_count_rate_meter.sv =====
// windowed_count_rate_meter: keeps sliding windows of count and converter samples and
// reports mean rate, mean converter value, progress in per mille and a stop request.
// A sample transaction is accepted, then the ring is updated. For a report, after accept,
// trimming reads the oldest entry through the ring RAM's registered port, then up to
// three divisions (56, 42 and 32 steps) run one quotient bit per cycle on the single
// shared divider. The block is not ready while it works, but takes a new transaction
// while a report waits at rsp. Stores need no clearing after reset. Depends on
// wcrm_pkg, wcrm_req_if, wcrm_rsp_if, wcrm_ring and wcrm_div.

module windowed_count_rate_meter (
   input  logic                            clock,
   input  logic                            reset,
   wcrm_req_if.sink                        req_chan,
   wcrm_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [wcrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcrm_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   wcrm_pkg::seq_state_type state_ff, state_in;

   // configuration
   logic                          window_mode_ff, window_mode_in;
   logic [wcrm_pkg::SAMPLE_W-1:0] target_ff, target_in;
   logic                          continuous_ff, continuous_in;
   logic [wcrm_pkg::RES_W-1:0]    time_res_ff, time_res_in;

   // captured request and report results
   logic [wcrm_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [wcrm_pkg::SAMPLE_W-1:0] value_ff, value_in;
   logic                          stop_ff, stop_in;
   logic                          many_ff, many_in;
   logic [wcrm_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [wcrm_pkg::PERM_W-1:0]   perm_ff, perm_in;
   logic [wcrm_pkg::SAMPLE_W-1:0] mean_ff, mean_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wcrm_pkg::RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic [wcrm_pkg::SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [wcrm_pkg::PERM_W-1:0]   rsp_perm_ff, rsp_perm_in;
   logic                          rsp_stop_ff, rsp_stop_in;

   wcrm_pkg::ring_cmd_type  cnt_cmd, adc_cmd;
   wcrm_pkg::ring_stat_type cnt_stat, adc_stat;
   wcrm_pkg::div_cmd_type   div_cmd;
   wcrm_pkg::div_stat_type  div_stat;
   logic [wcrm_pkg::NUM_W-1:0]  div_num;
   logic [wcrm_pkg::DEN_W-1:0]  div_den;
   logic [wcrm_pkg::NUM_W-1:0]  div_quot;

   logic [wcrm_pkg::SAMPLE_W-1:0]    tgt_eff;
   logic [wcrm_pkg::TOTAL_W-1:0]     cnt_fill_ext;
   logic [wcrm_pkg::TOTAL_W-1:0]     tgt_ext;
   logic [wcrm_pkg::TOTAL_W-1:0]     perm_base;
   logic [wcrm_pkg::PERM_PROD_W-1:0] perm_prod;
   logic [wcrm_pkg::DEN_W-1:0]       rate_den;
   logic                             cnt_drop;
   logic                             adc_drop;
   logic                             cnt_many;
   logic                             req_fire;
   logic                             rsp_free;

   assign tgt_eff      = (target_ff == '0) ? wcrm_pkg::SAMPLE_W'(1) : target_ff;
   assign cnt_fill_ext = wcrm_pkg::TOTAL_W'(cnt_stat.fill);
   assign tgt_ext      = wcrm_pkg::TOTAL_W'(tgt_eff);
   assign cnt_many     = (cnt_stat.fill > wcrm_pkg::FILL_W'(1));

   // mode 0 trims to target entries, mode 1 while more than one entry remains and the rest still exceeds target
   assign cnt_drop = window_mode_ff ?
                     (cnt_many &&
                      ((cnt_stat.total - wcrm_pkg::TOTAL_W'(cnt_stat.oldest)) > tgt_ext)) :
                     (cnt_fill_ext > tgt_ext);
   assign adc_drop = (adc_stat.fill > cnt_stat.fill);

   assign perm_base = window_mode_ff ? cnt_stat.total : cnt_fill_ext;
   assign perm_prod = wcrm_pkg::PERM_PROD_W'(perm_base) *
                      wcrm_pkg::PERM_PROD_W'(wcrm_pkg::PERM_SCALE);
   assign rate_den  = wcrm_pkg::DEN_W'(cnt_stat.fill) * wcrm_pkg::DEN_W'(time_res_ff);

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wcrm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action == wcrm_pkg::ACT_REPORT) begin
                  state_in = wcrm_pkg::ST_CNT_CHK;
               end else if (req_chan.frame_ok &&
                            ((req_chan.action == wcrm_pkg::ACT_COUNT) ||
                             (req_chan.action == wcrm_pkg::ACT_ADC))) begin
                  state_in = wcrm_pkg::ST_PUSH;
               end
            end
         end
         wcrm_pkg::ST_PUSH:     state_in = wcrm_pkg::ST_IDLE;
         wcrm_pkg::ST_CNT_CHK: begin
            state_in = cnt_drop ? wcrm_pkg::ST_CNT_WAIT : wcrm_pkg::ST_ADC_CHK;
         end
         wcrm_pkg::ST_CNT_WAIT: state_in = wcrm_pkg::ST_CNT_CHK;
         wcrm_pkg::ST_ADC_CHK: begin
            state_in = adc_drop ? wcrm_pkg::ST_ADC_WAIT : wcrm_pkg::ST_RATE_LD;
         end
         wcrm_pkg::ST_ADC_WAIT: state_in = wcrm_pkg::ST_ADC_CHK;
         wcrm_pkg::ST_RATE_LD: begin
            state_in = (cnt_stat.total == '0) ? wcrm_pkg::ST_PERM_LD : wcrm_pkg::ST_RATE_RUN;
         end
         wcrm_pkg::ST_RATE_RUN: begin
            if (div_stat.done) state_in = wcrm_pkg::ST_PERM_LD;
         end
         wcrm_pkg::ST_PERM_LD: begin
            state_in = many_ff ? wcrm_pkg::ST_PERM_RUN : wcrm_pkg::ST_MEAN_LD;
         end
         wcrm_pkg::ST_PERM_RUN: begin
            if (div_stat.done) state_in = wcrm_pkg::ST_MEAN_LD;
         end
         wcrm_pkg::ST_MEAN_LD: begin
            state_in = (adc_stat.fill == '0) ? wcrm_pkg::ST_DONE : wcrm_pkg::ST_MEAN_RUN;
         end
         wcrm_pkg::ST_MEAN_RUN: begin
            if (div_stat.done) state_in = wcrm_pkg::ST_DONE;
         end
         wcrm_pkg::ST_DONE: begin
            if (rsp_free) state_in = wcrm_pkg::ST_IDLE;
         end
         default: state_in = wcrm_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: request ready, ring commands and divider loads
   always_comb begin
      req_chan.ready = 1'b0;
      cnt_cmd        = '0;
      adc_cmd        = '0;
      div_cmd        = '0;
      div_num        = '0;
      div_den        = '0;
      unique case (state_ff)
         wcrm_pkg::ST_IDLE: req_chan.ready = 1'b1;
         wcrm_pkg::ST_PUSH: begin
            cnt_cmd.push = (act_ff == wcrm_pkg::ACT_COUNT);
            adc_cmd.push = (act_ff == wcrm_pkg::ACT_ADC);
         end
         wcrm_pkg::ST_CNT_CHK: cnt_cmd.drop = cnt_drop;
         wcrm_pkg::ST_ADC_CHK: adc_cmd.drop = adc_drop;
         wcrm_pkg::ST_RATE_LD: begin
            div_cmd.start = (cnt_stat.total != '0);
            div_cmd.steps = wcrm_pkg::STEP_W'(wcrm_pkg::NUM_W);
            div_num       = wcrm_pkg::NUM_W'(cnt_stat.total) << wcrm_pkg::RATE_SHIFT;
            div_den       = rate_den;
         end
         wcrm_pkg::ST_PERM_LD: begin
            div_cmd.start = many_ff;
            div_cmd.steps = wcrm_pkg::STEP_W'(wcrm_pkg::PERM_PROD_W);
            div_num       = wcrm_pkg::NUM_W'(perm_prod) << wcrm_pkg::PERM_ALIGN;
            div_den       = wcrm_pkg::DEN_W'(tgt_eff);
         end
         wcrm_pkg::ST_MEAN_LD: begin
            div_cmd.start = (adc_stat.fill != '0);
            div_cmd.steps = wcrm_pkg::STEP_W'(wcrm_pkg::TOTAL_W);
            div_num       = wcrm_pkg::NUM_W'(adc_stat.total) << wcrm_pkg::MEAN_ALIGN;
            div_den       = wcrm_pkg::DEN_W'(adc_stat.fill);
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      window_mode_in = window_mode_ff;
      target_in      = target_ff;
      continuous_in  = continuous_ff;
      time_res_in    = time_res_ff;
      act_in         = act_ff;
      value_in       = value_ff;
      stop_in        = stop_ff;
      many_in        = many_ff;
      rate_in        = rate_ff;
      perm_in        = perm_ff;
      mean_in        = mean_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_perm_in    = rsp_perm_ff;
      rsp_stop_in    = rsp_stop_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            wcrm_pkg::CSR_WINDOW_MODE: window_mode_in = csr_wr_data[0];
            wcrm_pkg::CSR_TARGET:      target_in      = csr_wr_data[wcrm_pkg::SAMPLE_W-1:0];
            wcrm_pkg::CSR_CONTINUOUS:  continuous_in  = csr_wr_data[0];
            wcrm_pkg::CSR_TIME_RES:    time_res_in    = csr_wr_data[wcrm_pkg::RES_W-1:0];
         endcase
      end

      if (req_fire) begin
         act_in   = req_chan.action;
         value_in = req_chan.value;
         // stop and the progress gate look at the window before trimming
         many_in  = cnt_many;
         stop_in  = cnt_many && !continuous_ff &&
                    (window_mode_ff ? (cnt_stat.total >= tgt_ext) : (cnt_fill_ext >= tgt_ext));
      end

      unique case (state_ff)
         wcrm_pkg::ST_RATE_LD:  rate_in = '0;
         wcrm_pkg::ST_RATE_RUN: begin
            if (div_stat.done) begin
               rate_in = (|div_quot[wcrm_pkg::NUM_W-1:wcrm_pkg::RATE_W]) ?
                         '1 : div_quot[wcrm_pkg::RATE_W-1:0];
            end
         end
         wcrm_pkg::ST_PERM_LD:  perm_in = '0;
         wcrm_pkg::ST_PERM_RUN: begin
            if (div_stat.done) begin
               perm_in = (|div_quot[wcrm_pkg::NUM_W-1:wcrm_pkg::PERM_W]) ?
                         '1 : div_quot[wcrm_pkg::PERM_W-1:0];
            end
         end
         wcrm_pkg::ST_MEAN_LD:  mean_in = '0;
         wcrm_pkg::ST_MEAN_RUN: begin
            if (div_stat.done) mean_in = div_quot[wcrm_pkg::SAMPLE_W-1:0];
         end
         default: begin
         end
      endcase

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == wcrm_pkg::ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_rate_in  = rate_ff;
         rsp_mean_in  = mean_ff;
         rsp_perm_in  = perm_ff;
         rsp_stop_in  = stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= wcrm_pkg::ST_IDLE;
         window_mode_ff <= wcrm_pkg::MODE_SAMPLES;
         target_ff      <= wcrm_pkg::TARGET_INIT;
         continuous_ff  <= wcrm_pkg::CONT_INIT;
         time_res_ff    <= wcrm_pkg::TIME_RES_INIT;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_mode_ff <= window_mode_in;
         target_ff      <= target_in;
         continuous_ff  <= continuous_in;
         time_res_ff    <= time_res_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      act_ff      <= act_in;
      value_ff    <= value_in;
      stop_ff     <= stop_in;
      many_ff     <= many_in;
      rate_ff     <= rate_in;
      perm_ff     <= perm_in;
      mean_ff     <= mean_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_perm_ff <= rsp_perm_in;
      rsp_stop_ff <= rsp_stop_in;
   end

   wcrm_ring u_cnt_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cnt_cmd),
      .push_value (value_ff),
      .stat       (cnt_stat)
   );

   wcrm_ring u_adc_ring (
      .clock      (clock),
      .reset      (reset),
      .cmd        (adc_cmd),
      .push_value (value_ff),
      .stat       (adc_stat)
   );

   wcrm_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.mean_rate          = rsp_rate_ff;
   assign rsp_chan.adc_mean           = rsp_mean_ff;
   assign rsp_chan.completed_permille = rsp_perm_ff;
   assign rsp_chan.stop_request       = rsp_stop_ff;

   // divider is only started once the previous division has finished
   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // converter window never outgrows the count window by the time a report goes out
   a_adc_trimmed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcrm_pkg::ST_DONE) |-> (adc_stat.fill <= cnt_stat.fill))
      else $error("converter window longer than count window at report");

   // an empty count window carries a zero running sum
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (cnt_stat.fill == '0) |-> (cnt_stat.total == '0))
      else $error("count sum nonzero with empty window");

   // sample-count mode leaves at most target entries before the divisions
   a_mode0_trim: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wcrm_pkg::ST_RATE_LD) && !window_mode_ff) |-> (cnt_fill_ext <= tgt_ext))
      else $error("count window not trimmed to target");

endmodule

// ===== verif/wcrm_report_checker.sv =====
// wcrm_report_checker: watches the request, report and register ports of the rate meter,
// predicts every report from its own copy of both windows, and counts mismatches
// depends on wcrm_pkg, wcrm_req_if and wcrm_rsp_if
`timescale 1ns / 100ps

module wcrm_report_checker (
   input  logic                            clock,
   input  logic                            reset,
   wcrm_req_if                             req_mon,
   wcrm_rsp_if                             rsp_mon,
   input  logic                            csr_wr_en,
   input  logic [wcrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wcrm_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                              fail_count,
   output int                              reports_due
);
   import wcrm_pkg::*;

   typedef struct packed {
      logic [RATE_W-1:0]   mean_rate;
      logic [SAMPLE_W-1:0] adc_mean;
      logic [PERM_W-1:0]   permille;
      logic                stop;
   } meter_report_type;

   localparam int   CNT_WIN      = 0;
   localparam int   ADC_WIN      = 1;
   localparam int   EXP_DEPTH    = 8;
   localparam longint unsigned SAT_RATE = 64'hFFFF_FFFF;
   localparam longint unsigned SAT_PERM = 64'd65535;

   // sample windows: count at CNT_WIN, converter at ADC_WIN
   logic [SAMPLE_W-1:0] win_mem [2][WINDOW_DEPTH];
   int unsigned         win_head [2];
   int unsigned         win_fill [2];
   longint unsigned     win_sum [2];

   logic                mode_q;
   logic [SAMPLE_W-1:0] target_q;
   logic                cont_q;
   logic [RES_W-1:0]    tres_q;

   // expected reports in order, as a small ring
   meter_report_type    exp_reports [EXP_DEPTH];
   int unsigned         exp_wr;
   int unsigned         exp_rd;

   task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("[%0t] report mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   function automatic void win_drop(int w);
      if (win_fill[w] != 0) begin
         win_sum[w]  -= win_mem[w][win_head[w]];
         win_head[w]  = (win_head[w] + 1) % WINDOW_DEPTH;
         win_fill[w]--;
      end
   endfunction

   function automatic void win_push(int w, logic [SAMPLE_W-1:0] v);
      if (win_fill[w] >= WINDOW_DEPTH)
         win_drop(w);
      win_mem[w][(win_head[w] + win_fill[w]) % WINDOW_DEPTH] = v;
      win_sum[w] += v;
      win_fill[w]++;
   endfunction

   // trims both windows and works out the report that a report transaction returns
   function automatic meter_report_type compute_report();
      longint unsigned  tgt;
      longint unsigned  done_pm;
      longint unsigned  rate;
      longint unsigned  den;
      meter_report_type r;
      r       = '0;
      done_pm = 0;
      rate    = 0;
      tgt     = (target_q == '0) ? 64'd1 : longint'(target_q);
      if (win_fill[CNT_WIN] > 1) begin
         if (mode_q == MODE_SAMPLES) begin
            r.stop = !cont_q && (win_fill[CNT_WIN] >= tgt);
            while (win_fill[CNT_WIN] > tgt)
               win_drop(CNT_WIN);
            done_pm = 64'd1000 * win_fill[CNT_WIN] / tgt;
         end else begin
            r.stop = !cont_q && (win_sum[CNT_WIN] >= tgt);
            while (win_fill[CNT_WIN] > 1 &&
                   win_sum[CNT_WIN] - win_mem[CNT_WIN][win_head[CNT_WIN]] > tgt)
               win_drop(CNT_WIN);
            done_pm = 64'd1000 * win_sum[CNT_WIN] / tgt;
         end
      end
      r.permille = (done_pm > SAT_PERM) ? '1 : done_pm[PERM_W-1:0];

      // converter window never holds more entries than the count window
      while (win_fill[ADC_WIN] > win_fill[CNT_WIN])
         win_drop(ADC_WIN);

      if (win_fill[CNT_WIN] > 0 && win_sum[CNT_WIN] > 0) begin
         if (tres_q == '0) begin
            rate = SAT_RATE;
         end else begin
            den  = win_fill[CNT_WIN];
            den  = den * tres_q;
            rate = (win_sum[CNT_WIN] << RATE_SHIFT) / den;
            if (rate > SAT_RATE)
               rate = SAT_RATE;
         end
      end
      r.mean_rate = rate[RATE_W-1:0];
      if (win_fill[ADC_WIN] > 0)
         r.adc_mean = SAMPLE_W'(win_sum[ADC_WIN] / win_fill[ADC_WIN]);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      meter_report_type got;
      meter_report_type want;
      if (reset) begin
         for (int w = 0; w < 2; w++) begin
            win_head[w] = 0;
            win_fill[w] = 0;
            win_sum[w]  = 0;
         end
         mode_q   = MODE_SAMPLES;
         target_q = TARGET_INIT;
         cont_q   = CONT_INIT;
         tres_q   = TIME_RES_INIT;
         exp_wr   = 0;
         exp_rd   = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_WINDOW_MODE: mode_q   = csr_wr_data[0];
               CSR_TARGET:      target_q = csr_wr_data[SAMPLE_W-1:0];
               CSR_CONTINUOUS:  cont_q   = csr_wr_data[0];
               CSR_TIME_RES:    tres_q   = csr_wr_data[RES_W-1:0];
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.action)
               ACT_COUNT:  if (req_mon.frame_ok) win_push(CNT_WIN, req_mon.value);
               ACT_ADC:    if (req_mon.frame_ok) win_push(ADC_WIN, req_mon.value);
               ACT_REPORT: begin
                  exp_reports[exp_wr % EXP_DEPTH] = compute_report();
                  exp_wr++;
               end
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.mean_rate = rsp_mon.mean_rate;
            got.adc_mean  = rsp_mon.adc_mean;
            got.permille  = rsp_mon.completed_permille;
            got.stop      = rsp_mon.stop_request;
            if (exp_wr == exp_rd) begin
               flag_mismatch("unexpected report, mean_rate", 0, got.mean_rate);
            end else begin
               want = exp_reports[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got.mean_rate != want.mean_rate)
                  flag_mismatch("mean_rate", want.mean_rate, got.mean_rate);
               if (got.adc_mean != want.adc_mean)
                  flag_mismatch("adc_mean", want.adc_mean, got.adc_mean);
               if (got.permille != want.permille)
                  flag_mismatch("completed_permille", want.permille, got.permille);
               if (got.stop != want.stop)
                  flag_mismatch("stop_request", want.stop, got.stop);
            end
         end
      end
      reports_due = int'(exp_wr - exp_rd);
   end

endmodule

// ===== verif/tb_windowed_count_rate_meter.sv =====
// tb_windowed_count_rate_meter: clock, reset, register settings and sample/report
// stimulus for the rate meter, with the report checker beside it
// depends on wcrm_pkg, wcrm_req_if, wcrm_rsp_if, windowed_count_rate_meter, wcrm_report_checker
`timescale 1ns / 100ps

module tb_windowed_count_rate_meter;
   import wcrm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 2000;
   localparam int DRAIN_CYCLES = 300;
   localparam int QUIET_CYCLES = 8;
   localparam int PHASES       = 8;
   localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    fail_count;
   int                    reports_due;
   bit                    idle_on;
   int                    stall_reqs;
   int unsigned           cycle_count;

   wcrm_req_if req_bus ();
   wcrm_rsp_if rsp_bus ();

   windowed_count_rate_meter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   wcrm_report_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .reports_due (reports_due)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // report receiver: random back-pressure plus one long hold-off on request
   initial begin
      int stalls_done;
      stalls_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_reqs != stalls_done) begin
            stalls_done = stall_reqs;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < 32);
         end
      end
   end

   // valid stays high from one transaction to the next unless a gap is drawn
   task automatic send_item(logic [ACTION_W-1:0] act, logic ok, logic [SAMPLE_W-1:0] val);
      while (idle_on && $urandom_range(0, 99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.frame_ok <= ok;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_value(int small_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return '0;
      if (r < 8)
         return '1;
      if (r < 8 + small_pct)
         return SAMPLE_W'($urandom_range(0, 1023));
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_random(int cnt_pct, int adc_pct, int small_pct);
      int                  r;
      logic [ACTION_W-1:0] act;
      r = $urandom_range(0, 99);
      if (r < cnt_pct)
         act = ACT_COUNT;
      else if (r < cnt_pct + adc_pct)
         act = ACT_ADC;
      else if (r < 97)
         act = ACT_REPORT;
      else
         act = ACT_UNUSED;
      send_item(act, $urandom_range(0, 99) >= 5, pick_value(small_pct));
   endtask

   // drop valid, wait for every report to come back, then let the block go quiet
   task automatic settle(int quiet);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (reports_due != 0);
      repeat (quiet) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic mode, logic [SAMPLE_W-1:0] tgt, logic cont,
                                logic [RES_W-1:0] tres);
      csr_write(CSR_WINDOW_MODE, CSR_DATA_W'(mode));
      csr_write(CSR_TARGET, CSR_DATA_W'(tgt));
      csr_write(CSR_CONTINUOUS, CSR_DATA_W'(cont));
      csr_write(CSR_TIME_RES, CSR_DATA_W'(tres));
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic                mode;
      logic [SAMPLE_W-1:0] tgt;
      logic                cont;
      logic [RES_W-1:0]    tres;
      int                  items;
      int                  cnt_pct;
      int                  adc_pct;
      int                  small_pct;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= ACT_COUNT;
      req_bus.frame_ok <= 1'b0;
      req_bus.value    <= '0;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_WINDOW_MODE;
      csr_wr_data      <= '0;
      idle_on          <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and single-entry windows, rejected frames, unused action, extremes
      send_item(ACT_REPORT, 1'b1, 24'h000000);
      send_item(ACT_REPORT, 1'b0, 24'hFFFFFF);
      send_item(ACT_COUNT,  1'b1, 24'hFFFFFF);
      send_item(ACT_REPORT, 1'b1, 24'h000000);
      send_item(ACT_COUNT,  1'b0, 24'h123456);
      send_item(ACT_UNUSED, 1'b1, 24'hABCDEF);
      send_item(ACT_ADC,    1'b0, 24'hFFFFFF);
      send_item(ACT_COUNT,  1'b1, 24'h000000);
      send_item(ACT_ADC,    1'b1, 24'hFFFFFF);
      send_item(ACT_ADC,    1'b1, 24'h000000);
      send_item(ACT_ADC,    1'b1, 24'h555555);
      send_item(ACT_REPORT, 1'b0, 24'h000000);
      send_item(ACT_COUNT,  1'b1, 24'hAAAAAA);
      send_item(ACT_COUNT,  1'b1, 24'h555555);
      send_item(ACT_UNUSED, 1'b0, 24'h000000);
      send_item(ACT_REPORT, 1'b1, 24'hFFFFFF);
      send_item(ACT_ADC,    1'b1, 24'h000000);
      send_item(ACT_REPORT, 1'b1, 24'h000000);
      settle(QUIET_CYCLES);

      for (int ph = 0; ph < PHASES; ph++) begin
         items     = 70;
         cnt_pct   = 55;
         adc_pct   = 25;
         small_pct = 30;
         case (ph)
            0: begin
               mode = MODE_SAMPLES; tgt = 24'd300; cont = 1'b0; tres = 32'd65536;
               items = 640;
            end
            1: begin
               mode = MODE_SAMPLES; tgt = 24'd1; cont = 1'b0; tres = 32'd1;
               cnt_pct = 45; adc_pct = 30;
            end
            2: begin
               mode = MODE_SUM; tgt = 24'd0; cont = 1'b0; tres = 32'hFFFF_FFFF;
               cnt_pct = 45; adc_pct = 30;
            end
            3: begin
               mode = MODE_SUM; tgt = 24'hFFFFFF; cont = 1'b1; tres = 32'd0;
               cnt_pct = 60; adc_pct = 20; small_pct = 70;
            end
            4: begin
               mode = MODE_SUM; tgt = SAMPLE_W'($urandom); cont = 1'($urandom_range(0, 1));
               tres = $urandom; cnt_pct = 50; small_pct = 40;
            end
            5: begin
               mode = MODE_SAMPLES; tgt = SAMPLE_W'($urandom_range(2, 40)); cont = 1'b0;
               tres = $urandom;
            end
            6: begin
               mode = MODE_SUM; tgt = SAMPLE_W'($urandom_range(1, 4096)); cont = 1'b0;
               tres = $urandom_range(1, 262144); small_pct = 80;
            end
            default: begin
               mode = MODE_SAMPLES; tgt = 24'hFFFFFF; cont = 1'b1; tres = 32'd65536;
            end
         endcase
         idle_on <= (ph != 1);
         apply_setting(mode, tgt, cont, tres);

         if (ph == 4) begin
            // receiver holds off while reports keep coming, so the block backs up
            stall_reqs <= stall_reqs + 1;
            for (int i = 0; i < 12; i++)
               send_item((i % 2 == 0) ? ACT_REPORT : ACT_COUNT, 1'b1, pick_value(small_pct));
         end

         for (int i = 0; i < items; i++) begin
            if (ph == 0)
               // first fill and wrap the count window, then the converter window
               send_random((i < 320) ? 93 : 3, (i < 320) ? 3 : 93, small_pct);
            else
               send_random(cnt_pct, adc_pct, small_pct);
         end
         settle(QUIET_CYCLES);
      end

      settle(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== windowed_count_rate_meter.f =====
sv/wcrm_pkg.sv
sv/wcrm_req_if.sv
sv/wcrm_rsp_if.sv
sv/wcrm_ram.sv
sv/wcrm_ring.sv
sv/wcrm_div.sv
sv/windowed_count_rate_meter.sv
verif/wcrm_report_checker.sv
verif/tb_windowed_count_rate_meter.sv
